### sv/ard_pkg.sv
// ----------------------------------------------------------------------------
// Address region decoder package
// Shared action codes, status codes and the control word that travels
// along the chain of region cells.
// ----------------------------------------------------------------------------
package ard_pkg;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OVERLAP = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISS    = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] action;
      logic       hit;
   } ard_ctrl_type;

endpackage

### sv/ard_cell.sv
// ----------------------------------------------------------------------------
// Address region decoder cell
// Holds one region as a start and an end address and checks the word that
// passes through it against that region, one cell per cycle.
// ----------------------------------------------------------------------------
module ard_cell #(
   parameter int ADDR_BITS = 64,
   parameter int IDX_W     = 3,
   parameter int CNT_W     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      count,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_start,
   input  logic [ADDR_BITS-1:0]  wr_end,
   input  ard_pkg::ard_ctrl_type i_ctrl,
   input  logic [IDX_W-1:0]      i_pos,
   input  logic [ADDR_BITS-1:0]  i_addr,
   input  logic [ADDR_BITS-1:0]  i_aend,
   input  logic [IDX_W-1:0]      i_index,
   input  logic [ADDR_BITS-1:0]  i_offset,
   input  logic [ADDR_BITS-1:0]  i_left,
   input  logic                  i_fits,
   output ard_pkg::ard_ctrl_type o_ctrl,
   output logic [IDX_W-1:0]      o_pos,
   output logic [ADDR_BITS-1:0]  o_addr,
   output logic [ADDR_BITS-1:0]  o_aend,
   output logic [IDX_W-1:0]      o_index,
   output logic [ADDR_BITS-1:0]  o_offset,
   output logic [ADDR_BITS-1:0]  o_left,
   output logic                  o_fits
);
   import ard_pkg::*;

   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS-1:0] end_ff;
   ard_ctrl_type         ctrl_ff, ctrl_in;
   logic [IDX_W-1:0]     pos_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] aend_ff;
   logic [IDX_W-1:0]     index_ff, index_in;
   logic [ADDR_BITS-1:0] offset_ff, offset_in;
   logic [ADDR_BITS-1:0] left_ff, left_in;
   logic                 fits_ff, fits_in;
   logic                 eligible;
   logic                 contains;
   logic                 reaches;

   assign eligible = i_ctrl.valid && !i_ctrl.hit && (CNT_W'(i_pos) < count);
   assign contains = (start_ff <= i_addr) && (i_addr < end_ff);
   assign reaches  = (i_addr <= start_ff) && (start_ff < i_aend);

   always_comb begin
      ctrl_in   = i_ctrl;
      index_in  = i_index;
      offset_in = i_offset;
      left_in   = i_left;
      fits_in   = i_fits;
      if (eligible) begin
         unique case (i_ctrl.action)
            ACT_ADD: begin
               ctrl_in.hit = contains || reaches;
            end
            ACT_LOOKUP: begin
               if (contains) begin
                  ctrl_in.hit = 1'b1;
                  index_in    = i_pos;
                  offset_in   = i_addr - start_ff;
                  left_in     = end_ff - i_addr;
                  fits_in     = !(i_aend > end_ff);
               end
            end
            default: begin
               ctrl_in = i_ctrl;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      pos_ff    <= IDX_W'(i_pos + 1'b1);
      addr_ff   <= i_addr;
      aend_ff   <= i_aend;
      index_ff  <= index_in;
      offset_ff <= offset_in;
      left_ff   <= left_in;
      fits_ff   <= fits_in;
      if (wr_en) begin
         start_ff <= wr_start;
         end_ff   <= wr_end;
      end
   end

   assign o_ctrl   = ctrl_ff;
   assign o_pos    = pos_ff;
   assign o_addr   = addr_ff;
   assign o_aend   = aend_ff;
   assign o_index  = index_ff;
   assign o_offset = offset_ff;
   assign o_left   = left_ff;
   assign o_fits   = fits_ff;

endmodule

### sv/address_region_decoder.sv
// ----------------------------------------------------------------------------
// Address region decoder
// Keeps a table of address regions in a row of cells and adds, looks up
// or clears regions, one command word at a time.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low; busy then stays high until the result is issued. The word walks the
// row of MAX_REGIONS region cells, one cell per cycle, and each cell that
// holds a region checks it against that region until one of them hits.
// The result appears on the rsp_ ports with rsp_valid high for exactly one
// cycle, after the word has passed the head register, the cell row and the
// result register; busy falls at the edge that raises rsp_valid, so a new
// word can be taken at the edge that ends the result cycle.
// An add that succeeds writes its region into the next free cell when the
// result is formed. Clear only resets the region count.
// Reset empties the table, drops busy and removes any word in flight.
// The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module address_region_decoder #(
   parameter int MAX_REGIONS = 8,
   parameter int ADDR_BITS   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_address,
   input  logic [63:0] req_span,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_region_index,
   output logic [63:0] rsp_region_offset,
   output logic [63:0] rsp_bytes_left,
   output logic        rsp_access_fits
);
   import ard_pkg::*;

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   logic                 accept;
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   ard_ctrl_type         head_ctrl_ff, head_ctrl_in;
   logic [ADDR_BITS-1:0] head_addr_ff;
   logic [ADDR_BITS-1:0] head_aend_ff;

   ard_ctrl_type         chain_ctrl   [0:MAX_REGIONS];
   logic [IDX_W-1:0]     chain_pos    [0:MAX_REGIONS];
   logic [ADDR_BITS-1:0] chain_addr   [0:MAX_REGIONS];
   logic [ADDR_BITS-1:0] chain_aend   [0:MAX_REGIONS];
   logic [IDX_W-1:0]     chain_index  [0:MAX_REGIONS];
   logic [ADDR_BITS-1:0] chain_offset [0:MAX_REGIONS];
   logic [ADDR_BITS-1:0] chain_left   [0:MAX_REGIONS];
   logic                 chain_fits   [0:MAX_REGIONS];

   ard_ctrl_type         tail_ctrl;
   logic                 add_ok;
   logic [MAX_REGIONS-1:0] wr_en;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_index_ff, rsp_index_in;
   logic [63:0]          rsp_offset_ff, rsp_offset_in;
   logic [63:0]          rsp_left_ff, rsp_left_in;
   logic                 rsp_fits_ff, rsp_fits_in;

   assign accept = start && !busy_ff;

   always_comb begin
      head_ctrl_in        = '0;
      head_ctrl_in.valid  = accept;
      head_ctrl_in.action = req_action;
   end

   assign chain_ctrl[0]   = head_ctrl_ff;
   assign chain_pos[0]    = '0;
   assign chain_addr[0]   = head_addr_ff;
   assign chain_aend[0]   = head_aend_ff;
   assign chain_index[0]  = '0;
   assign chain_offset[0] = '0;
   assign chain_left[0]   = '0;
   assign chain_fits[0]   = 1'b0;

   assign tail_ctrl = chain_ctrl[MAX_REGIONS];
   assign add_ok    = tail_ctrl.valid && (tail_ctrl.action == ACT_ADD) && !tail_ctrl.hit
                      && (count_ff < CNT_W'(MAX_REGIONS));

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      assign wr_en[i] = add_ok && (count_ff == CNT_W'(i));

      ard_cell #(
         .ADDR_BITS (ADDR_BITS),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count    (count_ff),
         .wr_en    (wr_en[i]),
         .wr_start (chain_addr[MAX_REGIONS]),
         .wr_end   (chain_aend[MAX_REGIONS]),
         .i_ctrl   (chain_ctrl[i]),
         .i_pos    (chain_pos[i]),
         .i_addr   (chain_addr[i]),
         .i_aend   (chain_aend[i]),
         .i_index  (chain_index[i]),
         .i_offset (chain_offset[i]),
         .i_left   (chain_left[i]),
         .i_fits   (chain_fits[i]),
         .o_ctrl   (chain_ctrl[i+1]),
         .o_pos    (chain_pos[i+1]),
         .o_addr   (chain_addr[i+1]),
         .o_aend   (chain_aend[i+1]),
         .o_index  (chain_index[i+1]),
         .o_offset (chain_offset[i+1]),
         .o_left   (chain_left[i+1]),
         .o_fits   (chain_fits[i+1])
      );
   end

   always_comb begin
      busy_in       = busy_ff;
      count_in      = count_ff;
      rsp_valid_in  = tail_ctrl.valid;
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      rsp_offset_in = '0;
      rsp_left_in   = '0;
      rsp_fits_in   = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tail_ctrl.valid) begin
         busy_in = 1'b0;
         unique case (tail_ctrl.action)
            ACT_ADD: begin
               if (tail_ctrl.hit) begin
                  rsp_status_in = ST_OVERLAP;
               end else if (!add_ok) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_index_in = 3'(count_ff);
                  count_in     = CNT_W'(count_ff + 1'b1);
               end
            end
            ACT_LOOKUP: begin
               if (tail_ctrl.hit) begin
                  rsp_index_in  = 3'(chain_index[MAX_REGIONS]);
                  rsp_offset_in = 64'(chain_offset[MAX_REGIONS]);
                  rsp_left_in   = 64'(chain_left[MAX_REGIONS]);
                  rsp_fits_in   = chain_fits[MAX_REGIONS];
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         head_ctrl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         head_ctrl_ff <= head_ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_addr_ff  <= req_address[ADDR_BITS-1:0];
      head_aend_ff  <= ADDR_BITS'(req_address[ADDR_BITS-1:0] + req_span[ADDR_BITS-1:0]);
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_fits_ff   <= rsp_fits_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_region_index  = rsp_index_ff;
   assign rsp_region_offset = rsp_offset_ff;
   assign rsp_bytes_left    = rsp_left_ff;
   assign rsp_access_fits   = rsp_fits_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("Region count exceeds the table size.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !rsp_valid_ff)
      else $error("Accepted word did not raise busy.");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("Result strobe held for more than one cycle.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> count_ff == CNT_W'(MAX_REGIONS))
      else $error("Full status reported while the table has room.");
`endif

endmodule
